// File: hw/rtl/mux_header_channel_demux_macros.svh
// Assertion macros used by the header demultiplexer RTL.
`ifndef MUX_HEADER_CHANNEL_DEMUX_MACROS_SVH
`define MUX_HEADER_CHANNEL_DEMUX_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge outside reset.
`define MHCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define MHCD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MHCD_ASSERT(lbl, prop, msg)
`define MHCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/mhcd_pkg.sv
// Types, codes and constants of the mux header channel demultiplexer.
`default_nettype none
package mhcd_pkg;

	localparam int unsigned NumChannels = 9;
	localparam int unsigned BufferBytes = 2048;
	localparam int unsigned HdrBytes    = 8;

	localparam int unsigned CfgW    = 9;
	localparam int unsigned ExtW    = (NumChannels > CfgW) ? NumChannels : CfgW;
	localparam int unsigned PlenW   = 11;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [15:0] MaxPayload = 16'(BufferBytes - HdrBytes);
	localparam logic [15:0] HdrMagic   = 16'h33fc;
	localparam logic [7:0]  NibbleMask = 8'hf0;
	localparam logic [7:0]  Ipv4Tag    = 8'h40;
	localparam logic [7:0]  Ipv6Tag    = 8'h60;

	localparam logic [CfgIdxW-1:0] CfgRunning = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgPresent = CfgIdxW'(1);

	typedef enum logic [3:0] {
		StDataOk       = 4'd0,
		StBadMagic     = 4'd1,
		StBadChannel   = 4'd2,
		StInactive     = 4'd3,
		StOpenAttach   = 4'd4,
		StOpenRegister = 4'd5,
		StAlreadyOpen  = 4'd6,
		StClosed       = 4'd7,
		StNotOpen      = 4'd8,
		StBadCommand   = 4'd9
	} status_t;

	typedef enum logic [7:0] {
		CmdData  = 8'd0,
		CmdOpen  = 8'd1,
		CmdClose = 8'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ProtoIpv4 = 2'd0,
		ProtoIpv6 = 2'd1,
		ProtoMap  = 2'd2
	} proto_t;

	typedef struct packed {
		logic [15:0] magic;
		logic [7:0]  command;
		logic [7:0]  channel;
		logic [15:0] length;
		logic [7:0]  first_byte;
	} hdr_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       channel;
		logic [PlenW-1:0] payload_len;
		logic             len_clamped;
		proto_t           protocol;
		logic [CfgW-1:0]  open_map;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/mhcd_decode.sv
// Header check, dispatch and open-map update for one registered header.
`default_nettype none
module mhcd_decode (
	input  wire mhcd_pkg::hdr_t                      hdr,
	input  wire logic [mhcd_pkg::CfgW-1:0]           running,
	input  wire logic [mhcd_pkg::CfgW-1:0]           present,
	input  wire logic [mhcd_pkg::NumChannels-1:0]    open_cur,
	output mhcd_pkg::result_t                        res,
	output logic [mhcd_pkg::NumChannels-1:0]         open_nxt
);

	logic [mhcd_pkg::NumChannels-1:0] hit;
	logic [mhcd_pkg::ExtW-1:0]        run_ext;
	logic [mhcd_pkg::ExtW-1:0]        pres_ext;
	logic [mhcd_pkg::ExtW-1:0]        open_ext;
	logic                             chan_ok;
	logic                             is_run;
	logic                             is_pres;
	logic                             is_open;
	logic [7:0]                       nibble;

	// One-hot channel select; channels beyond the register width read as zero.
	always_comb begin
		for (int i = 0; i < mhcd_pkg::NumChannels; i++) begin
			hit[i] = (hdr.channel == 8'(i));
		end
	end

	assign run_ext  = mhcd_pkg::ExtW'(running);
	assign pres_ext = mhcd_pkg::ExtW'(present);
	assign chan_ok  = (hdr.channel < 8'(mhcd_pkg::NumChannels));
	assign is_run   = |(hit & run_ext[mhcd_pkg::NumChannels-1:0]);
	assign is_pres  = |(hit & pres_ext[mhcd_pkg::NumChannels-1:0]);
	assign is_open  = |(hit & open_cur);
	assign nibble   = hdr.first_byte & mhcd_pkg::NibbleMask;
	assign open_ext = mhcd_pkg::ExtW'(open_nxt);

	always_comb begin
		res             = '0;
		res.channel     = hdr.channel;
		open_nxt        = open_cur;
		if (hdr.magic != mhcd_pkg::HdrMagic) begin
			res.status = mhcd_pkg::StBadMagic;
		end else if (!chan_ok) begin
			res.status = mhcd_pkg::StBadChannel;
		end else begin
			case (hdr.command)
				mhcd_pkg::CmdData: begin
					if (!is_run) begin
						res.status = mhcd_pkg::StInactive;
					end else begin
						res.status = mhcd_pkg::StDataOk;
						if (hdr.length > mhcd_pkg::MaxPayload) begin
							res.payload_len = mhcd_pkg::MaxPayload[mhcd_pkg::PlenW-1:0];
							res.len_clamped = 1'b1;
						end else begin
							res.payload_len = hdr.length[mhcd_pkg::PlenW-1:0];
						end
						if (nibble == mhcd_pkg::Ipv4Tag) begin
							res.protocol = mhcd_pkg::ProtoIpv4;
						end else if (nibble == mhcd_pkg::Ipv6Tag) begin
							res.protocol = mhcd_pkg::ProtoIpv6;
						end else begin
							res.protocol = mhcd_pkg::ProtoMap;
						end
					end
				end
				mhcd_pkg::CmdOpen: begin
					if (is_open) begin
						res.status = mhcd_pkg::StAlreadyOpen;
					end else begin
						open_nxt   = open_cur | hit;
						res.status = is_pres ? mhcd_pkg::StOpenAttach
							: mhcd_pkg::StOpenRegister;
					end
				end
				mhcd_pkg::CmdClose: begin
					if (!is_open) begin
						res.status = mhcd_pkg::StNotOpen;
					end else begin
						open_nxt   = open_cur & ~hit;
						res.status = mhcd_pkg::StClosed;
					end
				end
				default: begin
					res.status = mhcd_pkg::StBadCommand;
				end
			endcase
		end
		res.open_map = open_ext[mhcd_pkg::CfgW-1:0];
	end

endmodule
`default_nettype wire

// File: hw/rtl/mux_header_channel_demux.sv
// Top level of the mux header channel demultiplexer.
// Usage:
// One request on the input channel carries a received frame header (magic,
// command, channel, length) and the first payload byte. It is taken when
// in_valid is high and in_stall is low. Each request gives exactly one
// result request on the output channel, taken when out_valid is high and
// out_stall is low. The result holds a status code, the echoed channel, the
// clamped payload length with its clamp flag, the protocol class and the
// remote open-channel bitmap after the frame.
// The header is taken into the header register at the accepting edge; the
// check and bitmap update then land in the result register, once it can
// load, and out_valid rises.
// With no stall on the output, one header is taken every cycle.
// When the receiver stalls, the result register holds and the header
// register fills; in_stall then rises until the result is taken.
// The two interface masks are written over the cfg channel, which is
// always ready; writes are expected only while the block is idle.
// Reset clears both masks, the open-channel bitmap and both valid flags.
`default_nettype none
`include "mux_header_channel_demux_macros.svh"
module mux_header_channel_demux (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mhcd_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [mhcd_pkg::CfgW-1:0]        cfg_data,
	// Header input channel.
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [15:0]                      magic,
	input  wire logic [7:0]                       command,
	input  wire logic [7:0]                       channel,
	input  wire logic [15:0]                      length,
	input  wire logic [7:0]                       first_byte,
	// Result output channel.
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [3:0]                            status,
	output logic [7:0]                            channel_out,
	output logic [mhcd_pkg::PlenW-1:0]            payload_len,
	output logic                                  len_clamped,
	output logic [1:0]                            protocol,
	output logic [mhcd_pkg::CfgW-1:0]             open_map
);

	logic [mhcd_pkg::CfgW-1:0]        running_q;
	logic [mhcd_pkg::CfgW-1:0]        present_q;
	logic [mhcd_pkg::NumChannels-1:0] open_q;
	logic [mhcd_pkg::NumChannels-1:0] open_nxt;

	mhcd_pkg::hdr_t    hdr_s1;
	logic              valid_s1;
	mhcd_pkg::result_t res;
	mhcd_pkg::result_t res_s2;
	logic              valid_s2;

	logic out_free;
	logic adv_s1;

	// The config port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			present_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == mhcd_pkg::CfgRunning) begin
				running_q <= cfg_data;
			end else if (cfg_index == mhcd_pkg::CfgPresent) begin
				present_q <= cfg_data;
			end
		end
	end

	// The result register can load when it is empty or being drained.
	// The header register moves on whenever the result register can load,
	// so the input only stalls when both stages hold a request.
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			hdr_s1.magic      <= magic;
			hdr_s1.command    <= command;
			hdr_s1.channel    <= channel;
			hdr_s1.length     <= length;
			hdr_s1.first_byte <= first_byte;
		end
	end

	mhcd_decode u_decode (
		.hdr      (hdr_s1),
		.running  (running_q),
		.present  (present_q),
		.open_cur (open_q),
		.res      (res),
		.open_nxt (open_nxt)
	);

	// The bitmap commits exactly when the header's result is registered,
	// so the next header in line always sees the updated map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				open_q <= open_nxt;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = res_s2.status;
	assign channel_out = res_s2.channel;
	assign payload_len = res_s2.payload_len;
	assign len_clamped = res_s2.len_clamped;
	assign protocol    = res_s2.protocol;
	assign open_map    = res_s2.open_map;

	`MHCD_ASSERT(a_stall_needs_s1, !in_stall || valid_s1, "input stalled with empty stage")
	`MHCD_ASSERT(a_map_only_on_adv, !adv_s1 |=> $stable(open_q), "open map changed without a request")
	`MHCD_ASSERT(a_status_range, out_valid |-> (status <= mhcd_pkg::StBadCommand), "status code out of range")
	`MHCD_ASSERT(a_non_data_zero, (out_valid && (status != mhcd_pkg::StDataOk)) |-> ((payload_len == '0) && !len_clamped && (protocol == mhcd_pkg::ProtoIpv4)), "non-data result carries payload fields")
	`MHCD_ASSERT(a_clamp_value, (out_valid && len_clamped) |-> (payload_len == mhcd_pkg::MaxPayload[mhcd_pkg::PlenW-1:0]), "clamped length is not the buffer limit")

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the mux header channel demultiplexer.
`default_nettype none
module tb_top;
	import mhcd_pkg::*;

	// Cycle limit for the runaway guard, well above the slowest correct run.
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned RandomPhases = 6;
	localparam int unsigned PhaseItems   = 225;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index = CfgRunning;
	logic [CfgW-1:0]      cfg_data = '0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [15:0]          magic = '0;
	logic [7:0]           command = '0;
	logic [7:0]           channel = '0;
	logic [15:0]          length = '0;
	logic [7:0]           first_byte = '0;

	logic                 out_valid;
	logic                 out_stall;
	logic [3:0]           status;
	logic [7:0]           channel_out;
	logic [PlenW-1:0]     payload_len;
	logic                 len_clamped;
	logic [1:0]           protocol;
	logic [CfgW-1:0]      open_map;

	// The receiver stall is the OR of the per-result random stall and the
	// long hold-off used to back the block up into its input.
	logic                 rx_stall = 1'b0;
	logic                 hold_stall = 1'b0;
	int unsigned          hold_cycles = 0;
	assign out_stall = rx_stall | hold_stall;

	// Upper bounds for the idle cycles drawn per request on each side.
	// Zero gives stretches where a side never idles.
	int unsigned          tx_gap_max = 17;
	int unsigned          rx_gap_max = 17;

	int unsigned          err_count = 0;
	int unsigned          cycles = 0;

	// Predictor state: the two interface masks and the remote open bitmap.
	logic [CfgW-1:0]      running_mask = '0;
	logic [CfgW-1:0]      present_mask = '0;
	logic [CfgW-1:0]      remote_open_map = '0;
	result_t              expected_results[$];

	mux_header_channel_demux DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.magic       (magic),
		.command     (command),
		.channel     (channel),
		.length      (length),
		.first_byte  (first_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.channel_out (channel_out),
		.payload_len (payload_len),
		.len_clamped (len_clamped),
		.protocol    (protocol),
		.open_map    (open_map)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the result of one header and updates the open bitmap.
	// The checks run in a fixed order: magic, channel range, command.
	function automatic result_t demux_predict(hdr_t h);
		result_t r;
		r = '0;
		r.channel = h.channel;
		if (h.magic != HdrMagic) begin
			r.status = StBadMagic;
		end else if (int'(h.channel) >= int'(NumChannels)) begin
			r.status = StBadChannel;
		end else begin
			case (h.command)
				CmdData: begin
					// Only the running bit matters for data; the present
					// bit is ignored here.
					if (!running_mask[h.channel]) begin
						r.status = StInactive;
					end else begin
						r.status = StDataOk;
						if (h.length > MaxPayload) begin
							r.payload_len = PlenW'(MaxPayload);
							r.len_clamped = 1'b1;
						end else begin
							r.payload_len = PlenW'(h.length);
						end
						// The protocol comes from the top nibble even when
						// the payload is empty.
						if ((h.first_byte & NibbleMask) == Ipv4Tag)
							r.protocol = ProtoIpv4;
						else if ((h.first_byte & NibbleMask) == Ipv6Tag)
							r.protocol = ProtoIpv6;
						else
							r.protocol = ProtoMap;
					end
				end
				CmdOpen: begin
					if (remote_open_map[h.channel]) begin
						r.status = StAlreadyOpen;
					end else begin
						remote_open_map[h.channel] = 1'b1;
						r.status = present_mask[h.channel] ? StOpenAttach : StOpenRegister;
					end
				end
				CmdClose: begin
					if (!remote_open_map[h.channel]) begin
						r.status = StNotOpen;
					end else begin
						remote_open_map[h.channel] = 1'b0;
						r.status = StClosed;
					end
				end
				default: begin
					r.status = StBadCommand;
				end
			endcase
		end
		r.open_map = remote_open_map;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	// Everything is sampled at the rising edge. Inputs only move at the
	// falling edge, so the values seen here are the ones the block takes.
	// Input requests are predicted before outputs are checked; an output
	// taken at the same edge always belongs to an older request.
	always @(posedge clk) begin
		hdr_t    h;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgRunning: running_mask = cfg_data;
					CfgPresent: present_mask = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				h = '{magic: magic, command: command, channel: channel,
					length: length, first_byte: first_byte};
				expected_results.push_back(demux_predict(h));
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending, channel %0d", channel_out);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, status);
					check_field("channel_out", want.channel, channel_out);
					check_field("payload_len", want.payload_len, payload_len);
					check_field("len_clamped", want.len_clamped, len_clamped);
					check_field("protocol", want.protocol, protocol);
					check_field("open_map", want.open_map, open_map);
				end
			end
		end
	end

	// Receiver: before each result it stalls a random number of cycles,
	// then keeps stall low until a result has been taken.
	initial begin
		int unsigned gap;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			repeat (gap) begin
				@(negedge clk);
				rx_stall <= 1'b1;
			end
			@(negedge clk);
			rx_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Long hold-off: counts its own cycles while the sender keeps going,
	// so the result and header registers fill and in_stall rises.
	initial begin
		forever begin
			wait (hold_cycles != 0);
			@(negedge clk);
			hold_stall <= 1'b1;
			repeat (hold_cycles) @(negedge clk);
			hold_stall <= 1'b0;
			hold_cycles = 0;
		end
	end

	// Runaway guard.
	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	function automatic hdr_t make_header(logic [15:0] mg, logic [7:0] cmd, logic [7:0] ch,
			logic [15:0] len, logic [7:0] fb);
		hdr_t h;
		h = '{magic: mg, command: cmd, channel: ch, length: len, first_byte: fb};
		return h;
	endfunction

	// Sends one request after a random idle gap and returns once it is taken.
	// The payload is held steady for as long as the block stalls it.
	task automatic send_request(hdr_t h);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		magic      <= h.magic;
		command    <= h.command;
		channel    <= h.channel;
		length     <= h.length;
		first_byte <= h.first_byte;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Lowers valid and waits until every pending result has come back, which
	// also leaves the two-stage pipeline empty, then idles briefly.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Masks are only changed with the block empty.
	task automatic set_masks(logic [CfgW-1:0] running, logic [CfgW-1:0] present);
		drain();
		write_register(CfgRunning, running);
		write_register(CfgPresent, present);
	endtask

	// Mostly well-formed frames on valid channels so that the open bitmap
	// moves around; the rest is bad magic, out-of-range channels and
	// unsupported commands. Lengths are small, near the clamp limit or random.
	function automatic hdr_t rand_header();
		hdr_t        h;
		int unsigned pick;
		h.magic = ($urandom_range(0, 9) == 0) ? 16'($urandom) : HdrMagic;
		pick = $urandom_range(0, 19);
		h.channel = (pick < 17) ? 8'($urandom_range(0, NumChannels - 1)) : 8'($urandom);
		pick = $urandom_range(0, 19);
		if (pick < 9)
			h.command = CmdData;
		else if (pick < 13)
			h.command = CmdOpen;
		else if (pick < 17)
			h.command = CmdClose;
		else
			h.command = 8'($urandom);
		case ($urandom_range(0, 3))
			0:       h.length = 16'($urandom_range(0, 64));
			1:       h.length = 16'($urandom_range(2030, 2050));
			default: h.length = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0:       h.first_byte = {4'h4, 4'($urandom)};
			1:       h.first_byte = {4'h6, 4'($urandom)};
			default: h.first_byte = 8'($urandom);
		endcase
		return h;
	endfunction

	// Frames rejected before dispatch: the magic word is checked ahead of
	// the channel, and the channel ahead of the command.
	task automatic test_rejects();
		set_masks('1, '1);
		send_request(make_header(16'h0000, CmdOpen, 8'd0, 16'd10, 8'h45));
		send_request(make_header(16'hffff, CmdData, 8'd3, 16'hffff, 8'hff));
		send_request(make_header(16'h33fd, CmdData, 8'd255, 16'd0, 8'h60));
		send_request(make_header(HdrMagic, CmdOpen, 8'(NumChannels), 16'd0, 8'h00));
		send_request(make_header(HdrMagic, CmdData, 8'd255, 16'd100, 8'h40));
		send_request(make_header(HdrMagic, 8'd3, 8'd2, 16'd0, 8'h40));
		send_request(make_header(HdrMagic, 8'd255, 8'd8, 16'hffff, 8'hff));
	endtask

	// Data frames: a running bit is enough even without the present bit.
	// Lengths are tried at zero, at the limit, just past it and at the top.
	task automatic test_data_path();
		set_masks(9'h1fe, '0);
		send_request(make_header(HdrMagic, CmdData, 8'd0, 16'd20, 8'h45));
		send_request(make_header(HdrMagic, CmdData, 8'd1, 16'd0, 8'h4f));
		send_request(make_header(HdrMagic, CmdData, 8'd8, 16'd2040, 8'h60));
		send_request(make_header(HdrMagic, CmdData, 8'd4, 16'd2041, 8'h6a));
		send_request(make_header(HdrMagic, CmdData, 8'd5, 16'hffff, 8'hff));
		send_request(make_header(HdrMagic, CmdData, 8'd6, 16'd1, 8'h00));
		send_request(make_header(HdrMagic, CmdData, 8'd7, 16'd2039, 8'h5f));
	endtask

	// Open, repeated open, close, repeated close, with and without the
	// present bit, on both edge channels.
	task automatic test_open_close();
		set_masks('0, 9'h100);
		send_request(make_header(HdrMagic, CmdOpen, 8'd0, 16'd0, 8'h00));
		send_request(make_header(HdrMagic, CmdOpen, 8'd0, 16'd0, 8'h00));
		send_request(make_header(HdrMagic, CmdOpen, 8'd8, 16'd5, 8'h40));
		send_request(make_header(HdrMagic, CmdData, 8'd8, 16'd5, 8'h40));
		send_request(make_header(HdrMagic, CmdClose, 8'd0, 16'd0, 8'h00));
		send_request(make_header(HdrMagic, CmdClose, 8'd0, 16'd0, 8'h00));
		send_request(make_header(HdrMagic, CmdClose, 8'd8, 16'hffff, 8'hff));
	endtask

	// The receiver holds off for a long stretch while the sender pushes
	// back-to-back requests, so in_stall has to rise and hold the payload.
	task automatic test_output_hold();
		set_masks(9'h0f0, 9'h00f);
		tx_gap_max = 0;
		hold_cycles = 120;
		repeat (24) send_request(rand_header());
		tx_gap_max = 17;
	endtask

	// Random traffic over several mask settings, with the idle bounds of
	// each side redrawn now and then to mix busy and quiet stretches.
	task automatic test_random_traffic();
		logic [CfgW-1:0] run_set;
		logic [CfgW-1:0] pres_set;
		for (int p = 0; p < RandomPhases; p++) begin
			case (p)
				0:       begin run_set = '1; pres_set = '0; end
				1:       begin run_set = '0; pres_set = '1; end
				2:       begin run_set = '1; pres_set = '1; end
				default: begin run_set = CfgW'($urandom); pres_set = CfgW'($urandom); end
			endcase
			set_masks(run_set, pres_set);
			for (int i = 0; i < PhaseItems; i++) begin
				if (i % 50 == 0) begin
					tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
					rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
				end
				send_request(rand_header());
			end
		end
		tx_gap_max = 17;
		rx_gap_max = 17;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Straight out of reset both masks are clear, so data is inactive.
		send_request(make_header(HdrMagic, CmdData, 8'd2, 16'd64, 8'h45));
		test_rejects();
		test_data_path();
		test_open_close();
		test_output_hold();
		test_random_traffic();

		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
